@@ design/m4tu_pkg.sv @@
`default_nettype none
package m4tu_pkg;
  localparam int FRAC_BITS = 16;
  localparam int W = 32;
  // Width that holds a sum of four shifted products without overflow.
  localparam int SW = 2*W-FRAC_BITS+2;
  localparam logic signed [W-1:0] ONE_Q = W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [W-1:0] MAX_Q = 32'sh7fffffff;
  localparam logic signed [W-1:0] MIN_Q = 32'sh80000000;

  localparam logic [3:0] OP_LOAD = 4'd0;
  localparam logic [3:0] OP_IDENT = 4'd1;
  localparam logic [3:0] OP_TRANSL = 4'd2;
  localparam logic [3:0] OP_SCALE_XYZ = 4'd3;
  localparam logic [3:0] OP_SCALE_ALL = 4'd4;
  localparam logic [3:0] OP_ADD = 4'd5;
  localparam logic [3:0] OP_SUB = 4'd6;
  localparam logic [3:0] OP_MUL = 4'd7;
  localparam logic [3:0] OP_ROT = 4'd8;
  localparam logic [3:0] OP_XFORM = 4'd9;
  localparam logic [3:0] OP_READ = 4'd10;
  localparam logic [3:0] OP_CMP = 4'd11;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the input transaction
    logic exec;       // apply a one-step operation
    logic mul_step;   // compute one output row of the matrix product
    logic [1:0] mul_row;
    logic mul_commit; // copy the finished product into the matrix
    logic out_load;   // register the result
  } m4tu_cmd_t;

  function automatic logic signed [W-1:0] sat_q(input logic signed [SW-1:0] v);
    if (v > SW'(MAX_Q)) return MAX_Q;
    else if (v < SW'(MIN_Q)) return MIN_Q;
    else return v[W-1:0];
  endfunction

  // Exact product shifted right by FRAC_BITS (floor).
  function automatic logic signed [2*W-FRAC_BITS-1:0] fmul_q(
      input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    return p[2*W-1:FRAC_BITS];
  endfunction
endpackage
`default_nettype wire

@@ design/m4tu_ctrl.sv @@
`default_nettype none
module m4tu_ctrl
  import m4tu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [3:0] req_type,
  input  wire logic [1:0] row_index,
  output logic      out_valid,
  input  wire logic out_stall,
  output m4tu_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] op;
  logic [1:0] mrow;
  logic has_res;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign has_res = (op == OP_XFORM) || (op == OP_READ) || (op == OP_CMP);

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.mul_row = mrow;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load_req = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (op == OP_MUL && mrow == 2'd3) state_next = S_MUL;
        else if (has_res) state_next = S_OUT;
        else state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (mrow == 2'd3) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.mul_commit = 1'b1;
        state_next = S_IDLE;
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= '0;
      mrow <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_req) begin
        op <= req_type;
        mrow <= row_index;
      end else if (state == S_EXEC && state_next == S_MUL) begin
        mrow <= 2'd0;
      end else if (cmd.mul_step) begin
        mrow <= mrow + 2'd1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_after_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> $past(state) == S_EXEC) else $error("output without exec");
  a_commit_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_commit |-> $past(cmd.mul_step)) else $error("commit without product");
`endif
endmodule
`default_nettype wire

@@ design/m4tu_dpath.sv @@
`default_nettype none
module m4tu_dpath
  import m4tu_pkg::*;
(
  input  wire logic clk,
  input  wire m4tu_cmd_t cmd,
  input  wire logic [3:0] req_type,
  input  wire logic [1:0] row_index,
  input  wire logic [1:0] axis,
  input  wire logic signed [W-1:0] elem0,
  input  wire logic signed [W-1:0] elem1,
  input  wire logic signed [W-1:0] elem2,
  input  wire logic signed [W-1:0] elem3,
  input  wire logic rst,
  output logic signed [W-1:0] res0,
  output logic signed [W-1:0] res1,
  output logic signed [W-1:0] res2,
  output logic signed [W-1:0] res3,
  output logic row_equal
);
  logic signed [W-1:0] m [4][4];
  logic signed [W-1:0] pa [4][4];
  logic signed [W-1:0] tmp [4][4];
  logic signed [W-1:0] e [4];
  logic [3:0] op;
  logic [1:0] r, ax;
  logic signed [W-1:0] vec [4];
  logic signed [W-1:0] prow [4];
  logic signed [W-1:0] ns;
  logic signed [W-1:0] mrow_sel [4];

  assign ns = (e[1] == MIN_Q) ? MAX_Q : -e[1];
  always_comb for (int j = 0; j < 4; j++) mrow_sel[j] = m[r][j];

  // Transform: sixteen products, one row per output lane.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [SW-1:0] s;
      s = '0;
      for (int k = 0; k < 4; k++) s = s + SW'(fmul_q(m[i][k], e[k]));
      vec[i] = sat_q(s);
    end
  end

  // One output row of the product per step.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic signed [SW-1:0] s;
      s = '0;
      for (int k = 0; k < 4; k++) s = s + SW'(fmul_q(m[cmd.mul_row][k], pa[k][j]));
      prow[j] = sat_q(s);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op <= req_type; r <= row_index; ax <= axis;
      e[0] <= elem0; e[1] <= elem1; e[2] <= elem2; e[3] <= elem3;
    end
    if (cmd.mul_step)
      for (int j = 0; j < 4; j++) tmp[cmd.mul_row][j] <= prow[j];
    if (cmd.out_load) begin
      if (op == OP_XFORM) begin
        res0 <= vec[0]; res1 <= vec[1]; res2 <= vec[2]; res3 <= vec[3];
        row_equal <= 1'b0;
      end else begin
        res0 <= mrow_sel[0]; res1 <= mrow_sel[1];
        res2 <= mrow_sel[2]; res3 <= mrow_sel[3];
        row_equal <= (op == OP_CMP) && (mrow_sel[0] == e[0]) && (mrow_sel[1] == e[1])
                     && (mrow_sel[2] == e[2]) && (mrow_sel[3] == e[3]);
      end
    end
    if (rst) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) m[i][j] <= (i == j) ? ONE_Q : '0;
    end else if (cmd.mul_commit) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) m[i][j] <= tmp[i][j];
    end else if (cmd.exec) begin
      unique case (op)
        OP_LOAD: for (int j = 0; j < 4; j++) m[r][j] <= e[j];
        OP_IDENT:
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] <= (i == j) ? ONE_Q : '0;
        OP_TRANSL:
          for (int i = 0; i < 3; i++)
            m[i][3] <= sat_q(SW'(m[i][3]) + SW'(e[i]));
        OP_SCALE_XYZ:
          for (int i = 0; i < 3; i++) m[i][i] <= sat_q(SW'(fmul_q(m[i][i], e[i])));
        OP_SCALE_ALL:
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) m[i][j] <= sat_q(SW'(fmul_q(m[i][j], e[0])));
        OP_ADD: for (int j = 0; j < 4; j++) m[r][j] <= sat_q(SW'(m[r][j]) + SW'(e[j]));
        OP_SUB: for (int j = 0; j < 4; j++) m[r][j] <= sat_q(SW'(m[r][j]) - SW'(e[j]));
        OP_MUL: for (int j = 0; j < 4; j++) pa[r][j] <= e[j];
        OP_ROT: begin
          unique case (ax)
            AX_X: begin m[1][1] <= e[0]; m[2][2] <= e[0]; m[1][2] <= ns; m[2][1] <= e[1]; end
            AX_Y: begin m[0][0] <= e[0]; m[2][2] <= e[0]; m[0][2] <= e[1]; m[2][0] <= ns; end
            AX_Z: begin m[0][0] <= e[0]; m[1][1] <= e[0]; m[0][1] <= ns; m[1][0] <= e[1]; end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ design/matrix4_transform_unit_core.sv @@
`default_nettype none
// Fixed-point 4x4 matrix unit (Q16.16). Each input transaction carries an
// operation that updates the stored matrix or produces one result
// transaction (transform, read, compare). A transaction is loaded and then
// executed, and one that produces a result then registers it; the row of a
// matrix product that completes the right operand then forms the four product
// rows and commits them, since one row of sixteen multipliers forms one
// output row per cycle. Input is stalled while an item is in flight and
// while an unread result is held.
module matrix4_transform_unit_core
  import m4tu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [3:0] req_type,
  input  wire logic [1:0] row_index,
  input  wire logic [1:0] axis,
  input  wire logic signed [31:0] elem0,
  input  wire logic signed [31:0] elem1,
  input  wire logic signed [31:0] elem2,
  input  wire logic signed [31:0] elem3,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] res0,
  output logic signed [31:0] res1,
  output logic signed [31:0] res2,
  output logic signed [31:0] res3,
  output logic row_equal
);
  m4tu_cmd_t cmd;

  // The controller sequences each transaction; the datapath holds the matrix.
  m4tu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type, .row_index,
    .out_valid, .out_stall, .cmd
  );

  m4tu_dpath u_dpath (
    .clk, .cmd, .req_type, .row_index, .axis, .elem0, .elem1, .elem2, .elem3,
    .rst, .res0, .res1, .res2, .res3, .row_equal
  );
endmodule
`default_nettype wire
